// ===== rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text unit.
`default_nettype none

package sitda_pkg;

	// Field widths and character codes.
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
	localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
	localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CODE_MINUS = 8'd45;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic dabble;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic one_left;
		logic neg;
		logic slot_free;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/sitda_ctrl.sv =====
// Controller state machine that sequences conversion and character output.
`default_nettype none

module sitda_ctrl
	import sitda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (status.conv_last) begin
					state_nxt = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!(status.top_zero && !status.one_left)) begin
					state_nxt = status.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (status.slot_free) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.slot_free && status.one_left) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake and datapath commands.
	always_comb begin
		in_stall       = 1'b1;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CONV: begin
				cmd.dabble = 1'b1;
			end
			ST_SKIP: begin
				cmd.skip = status.top_zero && !status.one_left;
			end
			ST_SIGN: begin
				cmd.emit_sign = status.slot_free;
			end
			ST_EMIT: begin
				cmd.emit_digit = status.slot_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sitda_dp.sv =====
// Datapath: magnitude capture, shift-and-add-3 conversion and the output register.
`default_nettype none

module sitda_dp
	import sitda_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [VALUE_W-1:0]   value,
	input  wire cmd_t                 cmd,
	output status_t                   status,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [CHAR_W-1:0]    char_code,
	output logic                      last
);

	logic [VALUE_W-1:0]   mag_q;
	logic                 neg_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [DIG_CNT_W-1:0] dig_left_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_code_q;
	logic                 last_q;

	logic [BCD_W-1:0]     bcd_adj;
	logic [3:0]           top_digit;
	logic                 slot_free;

	// Add three to every digit of five or more ahead of the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign slot_free = !out_valid_q || !out_stall;

	// Status towards the controller.
	always_comb begin
		status.conv_last = (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1));
		status.top_zero  = (top_digit == 4'd0);
		status.one_left  = (dig_left_q == DIG_CNT_W'(1));
		status.neg       = neg_q;
		status.slot_free = slot_free;
	end

	// Working registers: magnitude, sign, digits and counters.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q      <= value[VALUE_W-1];
			mag_q      <= value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
			bcd_q      <= '0;
			bit_cnt_q  <= '0;
			dig_left_q <= DIG_CNT_W'(NUM_DIGITS);
		end else if (cmd.dabble) begin
			bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
			mag_q     <= {mag_q[VALUE_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q      <= {bcd_q[BCD_W-5:0], 4'd0};
			dig_left_q <= dig_left_q - DIG_CNT_W'(1);
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sign || cmd.emit_digit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_code_q <= CODE_MINUS;
			last_q      <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_code_q <= CODE_ZERO + {4'd0, top_digit};
			last_q      <= status.one_left;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Top level of the signed 32-bit integer to decimal ASCII text unit.
//
// Each input transaction carries one signed 32-bit value; the unit returns its decimal text
// as one output transaction per character, most significant first: a minus sign for negative
// values, then the digits without leading zeros ("0" for zero), with last set on the final
// character. The most negative value prints as -2147483648. One value is processed at a time:
// in_stall is low only while the unit is idle. A value passes through these steps in order:
// acceptance, the one-bit-per-cycle shift-and-add-3 conversion loop, discarding of leading
// zero digits, leaving that scan, then emission of a minus sign if needed and of each digit.
// A registered output stage holds the current character while the downstream side stalls.
`default_nettype none

module signed_int_to_decimal_ascii_unit
	import sitda_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [VALUE_W-1:0]  value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [CHAR_W-1:0]   char_code,
	output logic                     last
);

	cmd_t    cmd;
	status_t status;

	// Sequencing.
	sitda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Conversion and output register.
	sitda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== rtl/sitda_checker.sv =====
// Port-level checks for the decimal text unit and their binding to the top level.
`default_nettype none

module sitda_checker
	import sitda_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [CHAR_W-1:0]   char_code,
	input wire logic                last
);

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last))
		else $error("output payload changed while stalled");

	// Every character is a minus sign or a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == CODE_MINUS) ||
			((char_code >= CODE_ZERO) && (char_code <= CODE_ZERO + 8'd9)))
		else $error("character code out of range");

	// A minus sign never ends a run.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (char_code == CODE_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	// Once a value is taken the input is stalled straight after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted during conversion");

	// With the output idle, a value just taken does not make the output valid straight away.
	a_no_early_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("output appeared without conversion");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.char_code (char_code),
	.last      (last)
);

`default_nettype wire

// ===== sim/signed_int_to_decimal_ascii_unit_tb.sv =====
// Self-checking testbench for the signed integer to decimal ASCII text unit.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_tb;
	import sitda_pkg::*;

	localparam int unsigned DEC_RADIX  = 10;
	localparam int          RAND_ITEMS = 500;
	localparam int          TAIL_CYCLES = 60;
	localparam int          REPORT_MAX = 10;

	// One expected character of a number's text.
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	// Predicts the decimal text of every accepted value and checks the characters that come out.
	class decimal_text_board;
		text_char_t  want_q[$];
		int unsigned errors;
		int unsigned reported;

		function new();
			errors   = 0;
			reported = 0;
		endfunction

		// Queues the characters that one accepted value must produce.
		function void note_value(input logic [VALUE_W-1:0] v);
			logic [VALUE_W-1:0] mag;
			logic [3:0]         digs[$];
			text_char_t         ch;
			// The most negative value wraps to its unsigned magnitude here.
			mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
			do begin
				digs.push_front(4'(mag % DEC_RADIX));
				mag = mag / DEC_RADIX;
			end while (mag != 0);
			if (v[VALUE_W-1]) begin
				ch.code = CODE_MINUS;
				ch.last = 1'b0;
				want_q.push_back(ch);
			end
			foreach (digs[i]) begin
				ch.code = CODE_ZERO + CHAR_W'(digs[i]);
				ch.last = (i == digs.size() - 1);
				want_q.push_back(ch);
			end
		endfunction

		// Compares one output transaction with the oldest expected character.
		function void check_char(input logic [CHAR_W-1:0] code, input logic flag);
			text_char_t ch;
			if (want_q.size() == 0) begin
				errors++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("ERROR: unexpected character code %0d last %0b", code, flag);
				end
				return;
			end
			ch = want_q.pop_front();
			if (code !== ch.code || flag !== ch.last) begin
				errors++;
				if (reported < REPORT_MAX) begin
					reported++;
					$display("ERROR: expected code %0d last %0b, got code %0d last %0b",
						ch.code, ch.last, code, flag);
				end
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [VALUE_W-1:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [CHAR_W-1:0]  char_code;
	logic               last;

	decimal_text_board board;
	int                tx_quiet;
	int                rx_hold;
	int                rx_free;

	signed_int_to_decimal_ascii_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last      (last)
	);

	// Clock with a 20 ns period.
	always #10 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Presents one value and waits until the unit accepts the transaction.
	task automatic send_value(input logic [VALUE_W-1:0] v);
		int gap;
		if (tx_quiet > 0) begin
			tx_quiet--;
			gap = 0;
		end else begin
			gap = idle_len();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		board.note_value(v);
	endtask

	// Holds off the sender until every expected character has arrived.
	task automatic drain_text();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Random value with a spread of digit counts, signs and edge values.
	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		int unsigned        p10;
		int                 n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				n = $urandom_range(1, 10);
				if (n == 10) begin
					v = 32'd1000000000 + ($urandom % 32'd1147483648);
				end else begin
					p10 = 1;
					repeat (n) p10 = p10 * DEC_RADIX;
					v = $urandom % p10;
				end
				if ($urandom_range(0, 1) == 1)
					v = ~v + 1'b1;
			end
			6: begin
				p10 = 1;
				repeat ($urandom_range(0, 9)) p10 = p10 * DEC_RADIX;
				v = p10 + VALUE_W'($urandom_range(0, 2)) - 1'b1;
				if ($urandom_range(0, 1) == 1)
					v = ~v + 1'b1;
			end
			7: begin
				if ($urandom_range(0, 1) == 1)
					v = 32'h8000_0000 + VALUE_W'($urandom_range(0, 3));
				else
					v = 32'h7FFF_FFFF - VALUE_W'($urandom_range(0, 3));
			end
			default: v = VALUE_W'($urandom_range(0, 200)) - 32'd100;
		endcase
		return v;
	endfunction

	// Receiver back-pressure: random stalls, with stretches free of any stall.
	initial begin
		out_stall = 1'b0;
		rx_hold   = 0;
		rx_free   = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				rx_hold--;
			end else begin
				out_stall <= 1'b0;
				if (rx_free > 0)
					rx_free--;
				else
					case ($urandom_range(0, 9))
						0: rx_free = $urandom_range(20, 200);
						1, 2, 3: rx_hold = 1 + idle_len();
						default: ;
					endcase
			end
		end
	end

	// Every accepted output transaction is checked.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_char(char_code, last);
	end

	// Stimulus and final verdict.
	initial begin
		logic [VALUE_W-1:0] directed[$];
		board     = new();
		tx_quiet  = 0;
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		value     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero, single digits, digit-count boundaries and both extremes.
		directed = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
			32'd100, 32'd12345, -32'sd54321, 32'd999999999, 32'd1000000000,
			-32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'd2000000009, 32'hFFFF_FFF6};
		foreach (directed[i])
			send_value(directed[i]);
		drain_text();

		// Random values; some runs go back to back with no idling.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (tx_quiet == 0 && $urandom_range(0, 49) == 0)
				tx_quiet = $urandom_range(10, 40);
			if (i == RAND_ITEMS / 2)
				drain_text();
			send_value(rand_value());
		end
		in_valid <= 1'b0;

		// Wait for the remaining text, then watch for anything extra.
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			$display("ERROR: %0d expected characters never arrived", board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== signed_int_to_decimal_ascii_unit.f =====
rtl/sitda_pkg.sv
rtl/sitda_ctrl.sv
rtl/sitda_dp.sv
rtl/signed_int_to_decimal_ascii_unit.sv
rtl/sitda_checker.sv
sim/signed_int_to_decimal_ascii_unit_tb.sv
